// ===== rtl/ubds_pkg.sv =====
// Shared types, widths and clock constants for the UART baud divisor search.
package ubds_pkg;

    localparam int BAUD_W     = 24;
    localparam int OSC_W      = 6;
    localparam int DIV_OUT_W  = 16;
    localparam int CLK_W      = 27;
    localparam int DSR_W      = 29;
    localparam int CNT_W      = 5;
    localparam int TOL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OSC_W-1:0] MAX_OSC = OSC_W'(32);

    localparam logic [CLK_W-1:0] CLK_FAST_HZ = CLK_W'(80000000);
    localparam logic [CLK_W-1:0] CLK_SLOW_HZ = CLK_W'(40000000);
    localparam logic [CLK_W-1:0] CLK_26M_HZ  = CLK_W'(26000000);

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_FAST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_26M = CFG_IDX_W'(1);

    typedef logic [BAUD_W-1:0]     baud_t;
    typedef logic [OSC_W-1:0]      osc_t;
    typedef logic [DIV_OUT_W-1:0]  div_out_t;
    typedef logic [CLK_W-1:0]      clk_hz_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    function automatic clk_hz_t uart_clock(input logic fast, input logic x26);
        clk_hz_t hz;
        if (fast)
        begin
            hz = CLK_FAST_HZ;
        end
        else if (x26)
        begin
            hz = CLK_26M_HZ;
        end
        else
        begin
            hz = CLK_SLOW_HZ;
        end
        return hz;
    endfunction

endpackage

// ===== rtl/ubds_baud_if.sv =====
// Request channel carrying the requested baud rate.
interface ubds_baud_if;
    import ubds_pkg::*;

    logic  valid;
    logic  ready;
    baud_t baud;

    modport source (output valid, output baud, input ready);
    modport sink   (input valid, input baud, output ready);
endinterface

// ===== rtl/ubds_result_if.sv =====
// Response channel carrying the chosen oversample count and divisor.
interface ubds_result_if;
    import ubds_pkg::*;

    logic     valid;
    logic     ready;
    osc_t     oversample;
    div_out_t divisor;
    logic     found;

    modport source (output valid, output oversample, output divisor, output found, input ready);
    modport sink   (input valid, input oversample, input divisor, input found, output ready);
endinterface

// ===== rtl/ubds_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface ubds_cfg_if;
    import ubds_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/uart_baud_divisor_search_unit.sv =====
// UART baud divisor search: sequencer around a shared bit-serial divider.
//
//  channel | dir | signals                          | transaction
//  --------+-----+----------------------------------+------------------------------
//  req     | in  | valid ready baud                 | one requested baud rate
//  rsp     | out | valid ready oversample divisor found | one search result
//  cfg     | in  | valid ready index data           | one register write
//
//  Each division is set up in S_NOM or S_TRY, then yields one quotient bit per cycle.
//  A trial adds the error check in S_ERR and S_CHK; each count advances through S_NEXT.
//  A zero baud request goes from idle straight to S_FIN and returns a miss.
//  req is taken only while the sequencer is idle; the response register lets the next
//  request start while the previous result waits on rsp.ready.
//  Reset clears both registers to 0 and empties the response register.
module uart_baud_divisor_search_unit (
    input  logic clk,
    input  logic rst_n,
    ubds_baud_if.sink     req,
    ubds_result_if.source rsp,
    ubds_cfg_if.sink      cfg
);
    import ubds_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NOM  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_TRY  = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_NEXT = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]       st_reg, st_next;
    logic             clock_fast_reg, crystal_26m_reg;
    baud_t            baud_reg, baud_next;
    osc_t             osc_reg, osc_next;
    logic [1:0]       k_reg, k_next;
    clk_hz_t          nom_reg, nom_next;
    clk_hz_t          dv_reg, dv_next;
    clk_hz_t          err_reg, err_next;
    logic             hit_reg, hit_next;
    logic             div_nom_reg, div_nom_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    clk_hz_t          dvd_reg, dvd_next;
    clk_hz_t          quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             rsp_valid_reg, rsp_valid_next;
    osc_t             rsp_osc_reg, rsp_osc_next;
    div_out_t         rsp_div_reg, rsp_div_next;
    logic             rsp_found_reg, rsp_found_next;

    logic [DSR_W:0]          trial;
    logic                    qbit;
    clk_hz_t                 dv_try;
    logic [OSC_W+BAUD_W-1:0] prod_nom;
    logic [OSC_W+CLK_W-1:0]  prod_try;
    logic [TOL_W-1:0]        tol;

    assign req.ready  = (st_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.oversample = rsp_osc_reg;
    assign rsp.divisor    = rsp_div_reg;
    assign rsp.found      = rsp_found_reg;

    assign trial    = {rem_reg, dvd_reg[CLK_W-1]};
    assign qbit     = (trial >= {1'b0, dsr_reg});
    assign dv_try   = nom_reg + CLK_W'(k_reg) - CLK_W'(1);
    assign prod_nom = osc_reg * baud_reg;
    assign prod_try = osc_reg * dv_try;
    assign tol      = TOL_W'({err_reg, 4'b0}) + TOL_W'({err_reg, 2'b0});

    always_comb
    begin
        st_next        = st_reg;
        baud_next      = baud_reg;
        osc_next       = osc_reg;
        k_next         = k_reg;
        nom_next       = nom_reg;
        dv_next        = dv_reg;
        err_next       = err_reg;
        hit_next       = hit_reg;
        div_nom_next   = div_nom_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_osc_next   = rsp_osc_reg;
        rsp_div_next   = rsp_div_reg;
        rsp_found_next = rsp_found_reg;

        unique case (st_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    baud_next = req.baud;
                    osc_next  = MAX_OSC;
                    hit_next  = 1'b0;
                    st_next   = (req.baud == '0) ? S_FIN : S_NOM;
                end
            end
            S_NOM:
            begin
                dsr_next     = prod_nom[DSR_W-1:0];
                rem_next     = '0;
                dvd_next     = uart_clock(clock_fast_reg, crystal_26m_reg);
                quo_next     = '0;
                cnt_next     = CNT_W'(CLK_W);
                div_nom_next = 1'b1;
                st_next      = S_DIV;
            end
            S_DIV:
            begin
                rem_next = qbit ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
                quo_next = {quo_reg[CLK_W-2:0], qbit};
                dvd_next = {dvd_reg[CLK_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    if (div_nom_reg)
                    begin
                        nom_next = {quo_reg[CLK_W-2:0], qbit};
                        k_next   = 2'd0;
                        st_next  = ({quo_reg[CLK_W-2:0], qbit} == '0) ? S_NEXT : S_TRY;
                    end
                    else
                    begin
                        st_next = S_ERR;
                    end
                end
            end
            S_TRY:
            begin
                if (k_reg == 2'd3)
                begin
                    st_next = S_NEXT;
                end
                else if (dv_try == '0)
                begin
                    k_next = k_reg + 2'd1;
                end
                else
                begin
                    dv_next      = dv_try;
                    dsr_next     = prod_try[DSR_W-1:0];
                    rem_next     = '0;
                    dvd_next     = uart_clock(clock_fast_reg, crystal_26m_reg);
                    quo_next     = '0;
                    cnt_next     = CNT_W'(CLK_W);
                    div_nom_next = 1'b0;
                    st_next      = S_DIV;
                end
            end
            S_ERR:
            begin
                err_next = (quo_reg > CLK_W'(baud_reg)) ? (quo_reg - CLK_W'(baud_reg))
                                                        : (CLK_W'(baud_reg) - quo_reg);
                st_next  = S_CHK;
            end
            S_CHK:
            begin
                if (tol < TOL_W'(baud_reg))
                begin
                    hit_next = 1'b1;
                    st_next  = S_FIN;
                end
                else
                begin
                    k_next  = k_reg + 2'd1;
                    st_next = S_TRY;
                end
            end
            S_NEXT:
            begin
                if (osc_reg == OSC_W'(1))
                begin
                    st_next = S_FIN;
                end
                else
                begin
                    osc_next = osc_reg - OSC_W'(1);
                    st_next  = S_NOM;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_osc_next   = hit_reg ? osc_reg : '0;
                    rsp_div_next   = hit_reg ? dv_reg[DIV_OUT_W-1:0] : '0;
                    rsp_found_next = hit_reg;
                    st_next        = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= S_IDLE;
            rsp_valid_reg   <= 1'b0;
            clock_fast_reg  <= 1'b0;
            crystal_26m_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && (cfg.index == REG_CLOCK_FAST))
            begin
                clock_fast_reg <= cfg.data[0];
            end
            if (cfg.valid && (cfg.index == REG_CRYSTAL_26M))
            begin
                crystal_26m_reg <= cfg.data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        baud_reg      <= baud_next;
        osc_reg       <= osc_next;
        k_reg         <= k_next;
        nom_reg       <= nom_next;
        dv_reg        <= dv_next;
        err_reg       <= err_next;
        hit_reg       <= hit_next;
        div_nom_reg   <= div_nom_next;
        dsr_reg       <= dsr_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        rsp_osc_reg   <= rsp_osc_next;
        rsp_div_reg   <= rsp_div_next;
        rsp_found_reg <= rsp_found_next;
    end

    a_found_has_osc: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.oversample != '0))
        else $error("found result without oversample count");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> ((rsp.oversample == '0) && (rsp.divisor == '0)))
        else $error("miss result with nonzero fields");

    a_osc_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg != S_IDLE) && (st_reg != S_FIN)) |->
            ((osc_reg != '0) && (osc_reg <= MAX_OSC)))
        else $error("oversample count out of range during search");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("divider running with zero step count");

endmodule

// ===== tb/tb_uart_baud_divisor_search_unit.sv =====
// Self-checking testbench for the UART baud divisor search unit.
module tb_uart_baud_divisor_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ubds_pkg::*;

    localparam longint unsigned TOL_SCALE   = 100;
    localparam longint unsigned TOL_PERCENT = 5;

    localparam cfg_idx_t REG_SPARE_2 = cfg_idx_t'(2);
    localparam cfg_idx_t REG_SPARE_3 = cfg_idx_t'(3);

    localparam baud_t BAUD_MAX = baud_t'(24'hFFFFFF);

    typedef struct packed {
        osc_t     oversample;
        div_out_t divisor;
        logic     found;
    } search_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ubds_baud_if   req_if ();
    ubds_result_if rsp_if ();
    ubds_cfg_if    cfg_if ();

    uart_baud_divisor_search_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    baud_t          baud_queue[$];
    search_result_t expected_results[$];
    int unsigned    common_rates[$] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                        115200, 230400, 460800, 921600, 1000000, 1500000,
                                        2000000, 3000000, 4000000};

    logic cfg_fast = 1'b0;
    logic cfg_x26  = 1'b0;
    int   send_idle_pct;
    int   rcv_stall_pct;
    int   mismatches = 0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned clock_hz(input logic fast, input logic x26);
        longint unsigned hz;
        if (fast)
        begin
            hz = CLK_FAST_HZ;
        end
        else if (x26)
        begin
            hz = CLK_26M_HZ;
        end
        else
        begin
            hz = CLK_SLOW_HZ;
        end
        return hz;
    endfunction

    function automatic search_result_t find_divisor(input baud_t rate, input logic fast,
                                                    input logic x26);
        search_result_t  r;
        longint unsigned hz;
        longint unsigned want;
        longint unsigned osc;
        longint unsigned nom;
        longint unsigned dv;
        longint unsigned act;
        longint unsigned err;
        longint unsigned k;
        r.oversample = '0;
        r.divisor    = '0;
        r.found      = 1'b0;
        hz   = clock_hz(fast, x26);
        want = rate;
        if (want != 0)
        begin
            for (osc = MAX_OSC; osc > 0 && !r.found; osc--)
            begin
                nom = hz / (osc * want);
                if (nom != 0)
                begin
                    for (k = 0; k < 3 && !r.found; k++)
                    begin
                        dv = nom + k - 1;
                        if (dv != 0)
                        begin
                            act = hz / (osc * dv);
                            err = (act > want) ? act - want : want - act;
                            if (err * TOL_SCALE < want * TOL_PERCENT)
                            begin
                                r.oversample = osc_t'(osc);
                                r.divisor    = div_out_t'(dv);
                                r.found      = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic baud_t rand_baud();
        int unsigned     pick;
        int unsigned     width;
        longint unsigned v;
        longint unsigned osc;
        longint unsigned dv;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            v = common_rates[$urandom_range(common_rates.size() - 1)];
            v = v - v / 25 + $urandom_range(2 * v / 25);
        end
        else if (pick < 60)
        begin
            width = $urandom_range(24, 1);
            v = ($urandom & ((32'd1 << width) - 1)) | (32'd1 << (width - 1));
        end
        else if (pick < 80)
        begin
            v = $urandom_range(BAUD_MAX, 0);
        end
        else if (pick < 95)
        begin
            osc = $urandom_range(32, 1);
            dv  = $urandom_range(8, 1);
            v   = clock_hz(cfg_fast, cfg_x26) / (osc * dv);
            v   = v - v / 16 + $urandom_range(v / 8);
        end
        else
        begin
            case ($urandom_range(2))
                0: v = 0;
                1: v = 1;
                default: v = BAUD_MAX;
            endcase
        end
        if (v > BAUD_MAX)
        begin
            v = BAUD_MAX;
        end
        return baud_t'(v);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    task automatic add_random_rates(input int count);
        repeat (count)
        begin
            baud_queue.push_back(rand_baud());
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (baud_queue.size() != 0 || req_if.valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    // apply register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            case (cfg_if.index)
                REG_CLOCK_FAST:  cfg_fast <= cfg_if.data[0];
                REG_CRYSTAL_26M: cfg_x26  <= cfg_if.data[0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : baud_driver
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (req_if.valid)
            begin
                expected_results.push_back(find_divisor(req_if.baud, cfg_fast, cfg_x26));
            end
            if (baud_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_if.valid <= 1'b1;
                req_if.baud  <= baud_queue.pop_front();
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        search_result_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result osc=%0d div=%0d found=%0b",
                                            rsp_if.oversample, rsp_if.divisor, rsp_if.found));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.oversample !== want.oversample ||
                        rsp_if.divisor !== want.divisor || rsp_if.found !== want.found)
                    begin
                        note_mismatch($sformatf(
                            "expected osc=%0d div=%0d found=%0b, got osc=%0d div=%0d found=%0b",
                            want.oversample, want.divisor, want.found,
                            rsp_if.oversample, rsp_if.divisor, rsp_if.found));
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.baud   = '0;
        rsp_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_CLOCK_FAST;
        cfg_if.data   = '0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: 40 MHz clock
        baud_queue = '{baud_t'(0), baud_t'(1), baud_t'(2), BAUD_MAX, baud_t'(8388608),
                       baud_t'(16000000), baud_t'(300), baud_t'(9600), baud_t'(115200),
                       baud_t'(1250000), baud_t'(2500000), baud_t'(5000000),
                       baud_t'(13333333), baud_t'(12345), baud_t'(24'h555555),
                       baud_t'(24'hAAAAAA)};
        wait_drained();

        write_reg(REG_CRYSTAL_26M, cfg_data_t'(8'hFF));
        send_idle_pct = 76;
        add_random_rates(30);
        wait_drained();

        write_reg(REG_CLOCK_FAST, cfg_data_t'(8'h01));
        send_idle_pct = 0;
        rcv_stall_pct = 76;
        add_random_rates(30);
        wait_drained();

        write_reg(REG_SPARE_2, cfg_data_t'(8'hFF));
        write_reg(REG_SPARE_3, cfg_data_t'(8'h00));
        write_reg(REG_CLOCK_FAST, cfg_data_t'(8'hFE));
        write_reg(REG_CRYSTAL_26M, cfg_data_t'(8'h00));
        send_idle_pct = 18;
        rcv_stall_pct = 18;
        add_random_rates(30);
        wait_drained();

        write_reg(REG_CRYSTAL_26M, cfg_data_t'(8'h01));
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        baud_queue = '{baud_t'(0), baud_t'(1), BAUD_MAX, baud_t'(16000000)};
        add_random_rates(20);
        wait_drained();

        write_reg(REG_CLOCK_FAST, cfg_data_t'(8'h01));
        send_idle_pct = 76;
        rcv_stall_pct = 76;
        add_random_rates(15);
        wait_drained();

        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ubds_pkg.sv
rtl/ubds_baud_if.sv
rtl/ubds_result_if.sv
rtl/ubds_cfg_if.sv
rtl/uart_baud_divisor_search_unit.sv
tb/tb_uart_baud_divisor_search_unit.sv
